// ===== design/abz_pkg.sv =====
`timescale 1ns / 1ps
package abz_pkg;

  localparam int CORDIC_STEPS = 32;
  localparam int NORM_STEPS   = 6;
  localparam int DIV_STEPS    = 31;
  localparam int VXW          = 38;  // vectoring datapath width
  localparam int MW           = 34;  // magnitude width during prescale
  localparam int RTW          = 34;  // rotation datapath width
  localparam int NPTS         = 7;

  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  localparam logic signed [RTW-1:0] INV_GAIN = 34'sd652032874;

  localparam logic [1:0] ROLE_START = 2'd0;
  localparam logic [1:0] ROLE_CTRL1 = 2'd1;
  localparam logic [1:0] ROLE_CTRL2 = 2'd2;
  localparam logic [1:0] ROLE_END   = 2'd3;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic [30:0]        radius;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [1:0]         point_role;
    logic               degenerate;
    logic               last_point;
  } out_item_t;

  typedef struct packed {
    logic signed [VXW-1:0] x;
    logic signed [VXW-1:0] y;
    logic [MW-1:0]         m;
    logic [31:0]           z;
  } vec_t;

  typedef struct packed {
    logic signed [RTW-1:0] x;
    logic signed [RTW-1:0] y;
    logic signed [RTW-1:0] t;
  } rot_t;

  typedef struct packed {
    logic [62:0]          rem;
    logic [33:0]          den;
    logic [DIV_STEPS-1:0] q;
  } divst_t;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [30:0]        r;
    logic               degen;
  } side_a_t;

  typedef struct packed {
    side_a_t    a;
    logic       two;
    logic [3:0] neg;
  } side_b_t;

  typedef struct packed {
    side_a_t         a;
    logic            two;
    logic            kneg;
    logic            kpos;
    logic [5:0][31:0] trig;
  } side_c_t;

  // round to nearest, ties upward, of a Q30 product
  function automatic logic signed [33:0] rnd30(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p + 64'sd536870912;
    return s[63:30];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] res;
    if (v > 36'sd2147483647) begin
      res = 32'sh7FFFFFFF;
    end else if (v < -36'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

// ===== design/abz_norm_cell.sv =====
`timescale 1ns / 1ps
module abz_norm_cell #(
  parameter int SHIFT = 1
) (
  input  logic          clk,
  input  logic          en,
  input  abz_pkg::vec_t d_i,
  output abz_pkg::vec_t q_o
);

  abz_pkg::vec_t q_r, q_nxt;

  // shift up while the larger magnitude stays below 2^(MW)
  always_comb begin
    q_nxt = d_i;
    if ((d_i.m >> (abz_pkg::MW - SHIFT)) == '0) begin
      q_nxt.m = d_i.m << SHIFT;
      q_nxt.x = d_i.x <<< SHIFT;
      q_nxt.y = d_i.y <<< SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q_o = q_r;

endmodule

// ===== design/abz_vec_cell.sv =====
`timescale 1ns / 1ps
module abz_vec_cell #(
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          en,
  input  abz_pkg::vec_t d_i,
  output abz_pkg::vec_t q_o
);

  abz_pkg::vec_t q_r, q_nxt;
  logic signed [abz_pkg::VXW-1:0] xs, ys;

  always_comb begin
    xs = d_i.x >>> IDX;
    ys = d_i.y >>> IDX;
    q_nxt = d_i;
    if (d_i.y >= 0) begin
      q_nxt.x = d_i.x + ys;
      q_nxt.y = d_i.y - xs;
      q_nxt.z = d_i.z + abz_pkg::ATAN_TAB[IDX];
    end else begin
      q_nxt.x = d_i.x - ys;
      q_nxt.y = d_i.y + xs;
      q_nxt.z = d_i.z - abz_pkg::ATAN_TAB[IDX];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q_o = q_r;

endmodule

// ===== design/abz_rot_cell.sv =====
`timescale 1ns / 1ps
module abz_rot_cell #(
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          en,
  input  abz_pkg::rot_t d_i,
  output abz_pkg::rot_t q_o
);

  abz_pkg::rot_t q_r, q_nxt;
  logic signed [abz_pkg::RTW-1:0] xs, ys, at;

  always_comb begin
    xs = d_i.x >>> IDX;
    ys = d_i.y >>> IDX;
    at = $signed({2'b00, abz_pkg::ATAN_TAB[IDX]});
    q_nxt = d_i;
    if (d_i.t >= 0) begin
      q_nxt.x = d_i.x - ys;
      q_nxt.y = d_i.y + xs;
      q_nxt.t = d_i.t - at;
    end else begin
      q_nxt.x = d_i.x + ys;
      q_nxt.y = d_i.y - xs;
      q_nxt.t = d_i.t + at;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q_o = q_r;

endmodule

// ===== design/abz_div_cell.sv =====
`timescale 1ns / 1ps
module abz_div_cell #(
  parameter int BIT = 0
) (
  input  logic            clk,
  input  logic            en,
  input  abz_pkg::divst_t d_i,
  output abz_pkg::divst_t q_o
);

  abz_pkg::divst_t q_r, q_nxt;
  logic [63:0] dsh;

  // one restoring step: quotient bit BIT
  always_comb begin
    dsh   = {30'b0, d_i.den} << BIT;
    q_nxt = d_i;
    if ({1'b0, d_i.rem} >= dsh) begin
      q_nxt.rem    = d_i.rem - dsh[62:0];
      q_nxt.q[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q_o = q_r;

endmodule

// ===== design/arc_to_bezier_segmenter.sv =====
`timescale 1ns / 1ps
// Circular arc to cubic Bezier control points. Each input transfer is one arc; it yields one
// point (degenerate arc), four points (sweep up to a quarter turn) or seven points (two
// segments), one point per output cycle while out_stall is low, last_point marking the final
// one. The datapath is a 113-stage chain of cells (prescale, vectoring CORDIC, rotation
// CORDIC, restoring divider, products). Up to 114 arcs may be in flight (113 stages plus the
// point buffer); the sustained rate is set by the output port, with the input stalled only
// while the output side holds a finished arc and the point buffer is still busy.
module arc_to_bezier_segmenter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  abz_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output abz_pkg::out_item_t out_data
);

  localparam int FRONT = abz_pkg::NORM_STEPS + abz_pkg::CORDIC_STEPS;
  localparam int NSTG  = 2 + FRONT + 3 + abz_pkg::CORDIC_STEPS + 2 + abz_pkg::DIV_STEPS + 5;

  logic            adv;
  logic [NSTG-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  // ---------------- differences and degenerate check
  logic signed [32:0] dx0_r, dy0_r, dx2_r, dy2_r;
  abz_pkg::side_a_t   s0_side_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      dx0_r <= $signed({in_data.start_x[31], in_data.start_x})
             - $signed({in_data.center_x[31], in_data.center_x});
      dy0_r <= $signed({in_data.start_y[31], in_data.start_y})
             - $signed({in_data.center_y[31], in_data.center_y});
      dx2_r <= $signed({in_data.end_x[31], in_data.end_x})
             - $signed({in_data.center_x[31], in_data.center_x});
      dy2_r <= $signed({in_data.end_y[31], in_data.end_y})
             - $signed({in_data.center_y[31], in_data.center_y});
      s0_side_r.cx    <= in_data.center_x;
      s0_side_r.cy    <= in_data.center_y;
      s0_side_r.r     <= in_data.radius;
      s0_side_r.degen <= (in_data.radius == '0)
                      || (in_data.start_x == in_data.center_x
                          && in_data.start_y == in_data.center_y)
                      || (in_data.end_x == in_data.center_x
                          && in_data.end_y == in_data.center_y);
    end
  end

  // ---------------- half-plane fold for vectoring
  function automatic abz_pkg::vec_t vfold(input logic signed [32:0] dx,
                                          input logic signed [32:0] dy);
    abz_pkg::vec_t v;
    logic signed [abz_pkg::VXW-1:0] x, y;
    logic [abz_pkg::MW-1:0] ax, ay;
    x   = 38'(dx);
    y   = 38'(dy);
    v.z = '0;
    if (dx < 0) begin
      x   = -x;
      y   = -y;
      v.z = 32'h8000_0000;
    end
    ax  = x[abz_pkg::MW-1:0];
    ay  = (y < 0) ? 34'(-y) : 34'(y);
    v.m = (ax > ay) ? ax : ay;
    v.x = x;
    v.y = y;
    return v;
  endfunction

  abz_pkg::vec_t    vch [2][FRONT+1];
  abz_pkg::vec_t    v0_r, v1_r;
  abz_pkg::side_a_t sa_r [FRONT+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      v0_r     <= vfold(dx0_r, dy0_r);
      v1_r     <= vfold(dx2_r, dy2_r);
      sa_r[0]  <= s0_side_r;
    end
  end

  assign vch[0][0] = v0_r;
  assign vch[1][0] = v1_r;

  for (genvar v = 0; v < 2; v++) begin : g_vec
    for (genvar j = 0; j < abz_pkg::NORM_STEPS; j++) begin : g_norm
      abz_norm_cell #(.SHIFT(32 >> j)) u_norm (
        .clk(clk), .en(adv), .d_i(vch[v][j]), .q_o(vch[v][j+1])
      );
    end
    for (genvar j = 0; j < abz_pkg::CORDIC_STEPS; j++) begin : g_cor
      abz_vec_cell #(.IDX(j)) u_vec (
        .clk(clk), .en(adv),
        .d_i(vch[v][abz_pkg::NORM_STEPS+j]), .q_o(vch[v][abz_pkg::NORM_STEPS+j+1])
      );
    end
  end

  for (genvar j = 1; j <= FRONT; j++) begin : g_sa
    always_ff @(posedge clk) begin
      if (adv) begin
        sa_r[j] <= sa_r[j-1];
      end
    end
  end

  // ---------------- sweep and segment count
  logic [31:0]        diff;
  logic signed [32:0] sw, asw, half;
  logic               two;
  logic [31:0]        a0_r;
  logic signed [31:0] d_r;
  logic               two_r;
  abz_pkg::side_a_t   sA_side_r;

  always_comb begin
    diff = vch[1][FRONT].z - vch[0][FRONT].z;
    sw   = (diff == 32'h8000_0000) ? 33'sd2147483648 : 33'(signed'(diff));
    asw  = (sw < 0) ? -sw : sw;
    two  = asw > 33'sd1073741824;
    half = (sw + $signed({32'b0, sw[32]})) >>> 1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a0_r      <= vch[0][FRONT].z;
      d_r       <= two ? half[31:0] : sw[31:0];
      two_r     <= two;
      sA_side_r <= sa_r[FRONT];
    end
  end

  // ---------------- angles: d/4, segment start, segment ends
  logic [31:0]        ang_r [4];
  logic signed [31:0] dq;
  logic               sB_two_r;
  abz_pkg::side_a_t   sB_side_r;

  assign dq = d_r >>> 2;

  always_ff @(posedge clk) begin
    if (adv) begin
      ang_r[0]  <= dq;
      ang_r[1]  <= a0_r;
      ang_r[2]  <= a0_r + d_r;
      ang_r[3]  <= a0_r + (d_r <<< 1);
      sB_two_r  <= two_r;
      sB_side_r <= sA_side_r;
    end
  end

  // ---------------- fold into [-pi/2, pi/2] and start rotations
  abz_pkg::rot_t    rin [4];
  logic [3:0]       neg;
  abz_pkg::rot_t    rch [4][abz_pkg::CORDIC_STEPS+1];
  abz_pkg::side_b_t sb_r [abz_pkg::CORDIC_STEPS+1];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rin[k].x = abz_pkg::INV_GAIN;
      rin[k].y = '0;
      rin[k].t = 34'(signed'(ang_r[k]));
      neg[k]   = 1'b0;
      if (rin[k].t > 34'sd1073741824) begin
        rin[k].t = rin[k].t - 34'sd2147483648;
        neg[k]   = 1'b1;
      end else if (rin[k].t < -34'sd1073741824) begin
        rin[k].t = rin[k].t + 34'sd2147483648;
        neg[k]   = 1'b1;
      end
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_rin
    always_ff @(posedge clk) begin
      if (adv) begin
        rch[k][0] <= rin[k];
      end
    end
    for (genvar j = 0; j < abz_pkg::CORDIC_STEPS; j++) begin : g_rot
      abz_rot_cell #(.IDX(j)) u_rot (
        .clk(clk), .en(adv), .d_i(rch[k][j]), .q_o(rch[k][j+1])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_r[0].a   <= sB_side_r;
      sb_r[0].two <= sB_two_r;
      sb_r[0].neg <= neg;
    end
  end

  for (genvar j = 1; j <= abz_pkg::CORDIC_STEPS; j++) begin : g_sb
    always_ff @(posedge clk) begin
      if (adv) begin
        sb_r[j] <= sb_r[j-1];
      end
    end
  end

  // ---------------- cos/sin with fold sign restored
  logic signed [31:0] c_r [4];
  logic signed [31:0] s_r [4];
  abz_pkg::side_b_t   sD_side_r;

  for (genvar k = 0; k < 4; k++) begin : g_cs
    logic signed [abz_pkg::RTW-1:0] cx_v, sy_v;
    assign cx_v = sb_r[abz_pkg::CORDIC_STEPS].neg[k] ? -rch[k][abz_pkg::CORDIC_STEPS].x
                                                    : rch[k][abz_pkg::CORDIC_STEPS].x;
    assign sy_v = sb_r[abz_pkg::CORDIC_STEPS].neg[k] ? -rch[k][abz_pkg::CORDIC_STEPS].y
                                                    : rch[k][abz_pkg::CORDIC_STEPS].y;
    always_ff @(posedge clk) begin
      if (adv) begin
        c_r[k] <= cx_v[31:0];
        s_r[k] <= sy_v[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sD_side_r <= sb_r[abz_pkg::CORDIC_STEPS];
    end
  end

  // ---------------- k = 4 sin / (3 cos) in Q30, restoring divider
  abz_pkg::divst_t  dch [abz_pkg::DIV_STEPS+1];
  abz_pkg::side_c_t sc_r [abz_pkg::DIV_STEPS+1];
  logic [31:0]      ksa;
  logic [33:0]      den;

  assign ksa = (s_r[0] < 0) ? -s_r[0] : s_r[0];
  assign den = {c_r[0][31], c_r[0], 1'b0} + {{2{c_r[0][31]}}, c_r[0]};

  always_ff @(posedge clk) begin
    if (adv) begin
      dch[0].rem   <= {ksa[30:0], 32'b0};
      dch[0].den   <= den;
      dch[0].q     <= '0;
      sc_r[0].a    <= sD_side_r.a;
      sc_r[0].two  <= sD_side_r.two;
      sc_r[0].kneg <= s_r[0] < 0;
      sc_r[0].kpos <= c_r[0] > 0;
      sc_r[0].trig <= {s_r[3], c_r[3], s_r[2], c_r[2], s_r[1], c_r[1]};
    end
  end

  for (genvar j = 0; j < abz_pkg::DIV_STEPS; j++) begin : g_div
    abz_div_cell #(.BIT(abz_pkg::DIV_STEPS - 1 - j)) u_div (
      .clk(clk), .en(adv), .d_i(dch[j]), .q_o(dch[j+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        sc_r[j+1] <= sc_r[j];
      end
    end
  end

  // ---------------- products and point assembly
  logic [31:0]        qext;
  logic signed [31:0] kq_r;
  abz_pkg::side_c_t   sF_side_r, sG_side_r, sH_side_r;
  logic signed [63:0] rkp_r;
  logic signed [63:0] pr_r [6];
  logic signed [31:0] rk_r;
  logic signed [34:0] px_r [3];
  logic signed [34:0] py_r [3];
  logic signed [63:0] qr_r [6];
  logic signed [34:0] pxi_r [3];
  logic signed [34:0] pyi_r [3];
  logic               sI_degen_r, sI_two_r;
  logic signed [31:0] ptx_r [abz_pkg::NPTS];
  logic signed [31:0] pty_r [abz_pkg::NPTS];
  logic               sJ_degen_r, sJ_two_r;

  assign qext = {1'b0, dch[abz_pkg::DIV_STEPS].q};

  always_ff @(posedge clk) begin
    if (adv) begin
      if (!sc_r[abz_pkg::DIV_STEPS].kpos) begin
        kq_r <= '0;
      end else if (sc_r[abz_pkg::DIV_STEPS].kneg) begin
        kq_r <= -$signed(qext);
      end else begin
        kq_r <= $signed(qext);
      end
      sF_side_r <= sc_r[abz_pkg::DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rkp_r <= $signed({1'b0, sF_side_r.a.r}) * kq_r;
      for (int k = 0; k < 6; k++) begin
        pr_r[k] <= $signed({1'b0, sF_side_r.a.r}) * $signed(sF_side_r.trig[k]);
      end
      sG_side_r <= sF_side_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rk_r <= 32'(abz_pkg::rnd30(rkp_r));
      for (int k = 0; k < 3; k++) begin
        px_r[k] <= 35'(sG_side_r.a.cx) + 35'(abz_pkg::rnd30(pr_r[2*k]));
        py_r[k] <= 35'(sG_side_r.a.cy) + 35'(abz_pkg::rnd30(pr_r[2*k+1]));
      end
      sH_side_r <= sG_side_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 6; k++) begin
        qr_r[k] <= rk_r * $signed(sH_side_r.trig[k]);
      end
      for (int k = 0; k < 3; k++) begin
        pxi_r[k] <= px_r[k];
        pyi_r[k] <= py_r[k];
      end
      sI_degen_r <= sH_side_r.a.degen;
      sI_two_r   <= sH_side_r.two;
    end
  end

  // qr: rk*cos/sin of segment start, middle point, final point
  always_ff @(posedge clk) begin
    if (adv) begin
      ptx_r[0] <= abz_pkg::sat32(36'(pxi_r[0]));
      pty_r[0] <= abz_pkg::sat32(36'(pyi_r[0]));
      ptx_r[1] <= abz_pkg::sat32(36'(pxi_r[0]) - 36'(abz_pkg::rnd30(qr_r[1])));
      pty_r[1] <= abz_pkg::sat32(36'(pyi_r[0]) + 36'(abz_pkg::rnd30(qr_r[0])));
      ptx_r[2] <= abz_pkg::sat32(36'(pxi_r[1]) + 36'(abz_pkg::rnd30(qr_r[3])));
      pty_r[2] <= abz_pkg::sat32(36'(pyi_r[1]) - 36'(abz_pkg::rnd30(qr_r[2])));
      ptx_r[3] <= abz_pkg::sat32(36'(pxi_r[1]));
      pty_r[3] <= abz_pkg::sat32(36'(pyi_r[1]));
      ptx_r[4] <= abz_pkg::sat32(36'(pxi_r[1]) - 36'(abz_pkg::rnd30(qr_r[3])));
      pty_r[4] <= abz_pkg::sat32(36'(pyi_r[1]) + 36'(abz_pkg::rnd30(qr_r[2])));
      ptx_r[5] <= abz_pkg::sat32(36'(pxi_r[2]) + 36'(abz_pkg::rnd30(qr_r[5])));
      pty_r[5] <= abz_pkg::sat32(36'(pyi_r[2]) - 36'(abz_pkg::rnd30(qr_r[4])));
      ptx_r[6] <= abz_pkg::sat32(36'(pxi_r[2]));
      pty_r[6] <= abz_pkg::sat32(36'(pyi_r[2]));
      sJ_degen_r <= sI_degen_r;
      sJ_two_r   <= sI_two_r;
    end
  end

  // ---------------- point buffer and output sequencing
  logic signed [31:0] bx_r [abz_pkg::NPTS];
  logic signed [31:0] by_r [abz_pkg::NPTS];
  logic               bdeg_r, btwo_r;
  logic               busy_r, busy_nxt;
  logic [2:0]         idx_r, idx_nxt;
  logic               is_last, fire, take;
  logic [1:0]         role;

  assign is_last = bdeg_r || (btwo_r ? (idx_r == 3'd6) : (idx_r == 3'd3));
  assign fire    = busy_r && !out_stall;
  assign take    = !busy_r || (fire && is_last);
  assign adv     = !vld_r[NSTG-1] || take;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (take) begin
      busy_nxt = vld_r[NSTG-1];
      idx_nxt  = '0;
    end else if (fire) begin
      idx_nxt = idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && vld_r[NSTG-1]) begin
      bx_r   <= ptx_r;
      by_r   <= pty_r;
      bdeg_r <= sJ_degen_r;
      btwo_r <= sJ_two_r;
    end
  end

  always_comb begin
    unique case (idx_r) inside
      3'd0:       role = abz_pkg::ROLE_START;
      3'd1, 3'd4: role = abz_pkg::ROLE_CTRL1;
      3'd2, 3'd5: role = abz_pkg::ROLE_CTRL2;
      default:    role = abz_pkg::ROLE_END;
    endcase
  end

  always_comb begin
    if (bdeg_r) begin
      out_data.point_x    = '0;
      out_data.point_y    = '0;
      out_data.point_role = abz_pkg::ROLE_START;
      out_data.degenerate = 1'b1;
      out_data.last_point = 1'b1;
    end else begin
      out_data.point_x    = bx_r[idx_r];
      out_data.point_y    = by_r[idx_r];
      out_data.point_role = role;
      out_data.degenerate = 1'b0;
      out_data.last_point = is_last;
    end
  end

  assign out_valid = busy_r;
  assign in_stall  = !adv;

  a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_point && !out_data.degenerate
      |-> out_data.point_role == abz_pkg::ROLE_END)
    else $error("final point of an arc is not a segment end");

  a_degen_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |-> out_data.last_point)
    else $error("degenerate result is not the only point");

  a_idle_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while point buffer empty");

  a_arc_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_point |=> out_valid)
    else $error("arc interrupted before its last point");

endmodule

// ===== tb/tb_arc_to_bezier_segmenter.sv =====
`timescale 1ns / 1ps
module tb_arc_to_bezier_segmenter;

  localparam longint HALF_T    = 64'sd2147483648;
  localparam longint QUARTER_T = 64'sd1073741824;
  localparam longint INV_G     = 64'sd652032874;
  localparam int     LAT       = 114;
  localparam longint LIMIT     = 400000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  abz_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  abz_pkg::out_item_t out_data;

  int     fail_count = 0;
  int     arcs_sent = 0;
  int     degen_sent = 0;
  int     two_seg_sent = 0;
  longint cycle_count = 0;
  bit     hold_rx = 0;

  arc_to_bezier_segmenter u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // ---------------- fixed-point arc math ----------------
  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_q30(longint p);
    return (p + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] direction_angle(longint dx, longint dy);
    longint x, y, m, nx, ay;
    logic [31:0] z;
    x = dx;
    y = dy;
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h80000000;
    end
    ay = (y < 0) ? -y : y;
    m = (x > ay) ? x : ay;
    while (m < (64'sd1 <<< 33)) begin
      m = m * 2;
      x = x * 2;
      y = y * 2;
    end
    for (int i = 0; i < abz_pkg::CORDIC_STEPS; i++) begin
      if (y >= 0) begin
        nx = x + shr(y, i);
        y = y - shr(x, i);
        z = z + abz_pkg::ATAN_TAB[i];
      end else begin
        nx = x - shr(y, i);
        y = y + shr(x, i);
        z = z - abz_pkg::ATAN_TAB[i];
      end
      x = nx;
    end
    return z;
  endfunction

  function automatic void cos_sin(logic [31:0] ang, output longint c, output longint s);
    longint t, x, y, nx;
    bit flip;
    t = longint'(signed'(ang));
    x = INV_G;
    y = 0;
    flip = 0;
    if (t > QUARTER_T) begin
      t = t - HALF_T;
      flip = 1;
    end else if (t < -QUARTER_T) begin
      t = t + HALF_T;
      flip = 1;
    end
    for (int i = 0; i < abz_pkg::CORDIC_STEPS; i++) begin
      if (t >= 0) begin
        nx = x - shr(y, i);
        y = y + shr(x, i);
        t = t - longint'(abz_pkg::ATAN_TAB[i]);
      end else begin
        nx = x + shr(y, i);
        y = y - shr(x, i);
        t = t + longint'(abz_pkg::ATAN_TAB[i]);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // ---------------- scoreboard ----------------
  class bezier_scoreboard;
    abz_pkg::out_item_t pending_points[$];
    int                 checked;

    function void push_point(longint x, longint y, logic [1:0] role, logic dg, logic lst);
      abz_pkg::out_item_t p;
      p.point_x = clamp32(x);
      p.point_y = clamp32(y);
      p.point_role = role;
      p.degenerate = dg;
      p.last_point = lst;
      pending_points.push_back(p);
    endfunction

    // returns number of segments (0 for degenerate)
    function int note_arc(abz_pkg::in_item_t a);
      longint cx, cy, r, dx0, dy0, dx2, dy2, sw, asw, n, d, kc, ks, kq, rk;
      longint c0, s0, c1, s1, p0x, p0y, p3x, p3y;
      logic [31:0] a0, a2, diff, sa, ea;
      cx = a.center_x;
      cy = a.center_y;
      r = longint'(a.radius);
      dx0 = longint'(a.start_x) - cx;
      dy0 = longint'(a.start_y) - cy;
      dx2 = longint'(a.end_x) - cx;
      dy2 = longint'(a.end_y) - cy;
      if (r == 0 || (dx0 == 0 && dy0 == 0) || (dx2 == 0 && dy2 == 0)) begin
        push_point(0, 0, abz_pkg::ROLE_START, 1'b1, 1'b1);
        return 0;
      end
      a0 = direction_angle(dx0, dy0);
      a2 = direction_angle(dx2, dy2);
      diff = a2 - a0;
      sw = longint'(signed'(diff));
      if (sw == -HALF_T) sw = HALF_T;
      asw = (sw < 0) ? -sw : sw;
      n = (asw <= QUARTER_T) ? 1 : (asw + QUARTER_T - 1) / QUARTER_T;
      if (n > 2) n = 2;
      d = sw / n;
      cos_sin(d[33:2], kc, ks);
      kq = (kc > 0) ? (ks * 4 * (64'sd1 <<< 30)) / (3 * kc) : 0;
      rk = round_q30(r * kq);
      for (int m = 0; m < n; m++) begin
        sa = a0 + 32'(m * d);
        ea = sa + 32'(d);
        cos_sin(sa, c0, s0);
        cos_sin(ea, c1, s1);
        p0x = cx + round_q30(r * c0);
        p0y = cy + round_q30(r * s0);
        p3x = cx + round_q30(r * c1);
        p3y = cy + round_q30(r * s1);
        if (m == 0) push_point(p0x, p0y, abz_pkg::ROLE_START, 1'b0, 1'b0);
        push_point(p0x - round_q30(rk * s0), p0y + round_q30(rk * c0), abz_pkg::ROLE_CTRL1,
                   1'b0, 1'b0);
        push_point(p3x + round_q30(rk * s1), p3y - round_q30(rk * c1), abz_pkg::ROLE_CTRL2,
                   1'b0, 1'b0);
        push_point(p3x, p3y, abz_pkg::ROLE_END, 1'b0, m == n - 1);
      end
      return int'(n);
    endfunction

    function void check_point(abz_pkg::out_item_t got);
      abz_pkg::out_item_t want;
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected point, expected none, actual %h", $time, got);
        fail_count++;
        return;
      end
      want = pending_points.pop_front();
      checked++;
      if (got.point_x !== want.point_x) begin
        $display("%0t: point_x expected %h actual %h", $time, want.point_x, got.point_x);
        fail_count++;
      end
      if (got.point_y !== want.point_y) begin
        $display("%0t: point_y expected %h actual %h", $time, want.point_y, got.point_y);
        fail_count++;
      end
      if (got.point_role !== want.point_role) begin
        $display("%0t: point_role expected %0d actual %0d", $time, want.point_role,
                 got.point_role);
        fail_count++;
      end
      if (got.degenerate !== want.degenerate) begin
        $display("%0t: degenerate expected %b actual %b", $time, want.degenerate,
                 got.degenerate);
        fail_count++;
      end
      if (got.last_point !== want.last_point) begin
        $display("%0t: last_point expected %b actual %b", $time, want.last_point,
                 got.last_point);
        fail_count++;
      end
    endfunction
  endclass

  bezier_scoreboard points_sb = new();

  // ---------------- clock, reset, watchdog ----------------
  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("arc_to_bezier_segmenter regression: fail");
      $finish;
    end
  end

  // ---------------- sender ----------------
  // called at a falling edge; valid stays high into the next call when it has no gap
  task automatic send_arc(abz_pkg::in_item_t a);
    int gap, segs;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= a;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    segs = points_sb.note_arc(a);
    arcs_sent++;
    if (segs == 0) degen_sent++;
    if (segs == 2) two_seg_sent++;
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand32();
    return $urandom;
  endfunction

  // scale picks magnitudes from tiny (1 to 64) up to 2^30 - 1
  function automatic longint rand_mag();
    case ($urandom_range(0, 3))
      0: return $urandom_range(1, 64);
      1: return $urandom_range(1, 32'h0000FFFF);
      2: return $urandom_range(1, 32'h00FFFFFF);
      default: return $urandom_range(1, 32'h3FFFFFFF);
    endcase
  endfunction

  function automatic abz_pkg::in_item_t rand_arc();
    abz_pkg::in_item_t a;
    longint cx, cy, m;
    int kind;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      a.center_x = $urandom;
      a.center_y = $urandom;
      a.radius = 31'($urandom);
      a.start_x = $urandom;
      a.start_y = $urandom;
      a.end_x = $urandom;
      a.end_y = $urandom;
      return a;
    end
    m = rand_mag();
    cx = longint'(rand32()) >>> $urandom_range(0, 31);
    cy = longint'(rand32()) >>> $urandom_range(0, 31);
    a.center_x = 32'(cx);
    a.center_y = 32'(cy);
    a.radius = (kind == 1) ? 31'd0 : 31'(rand_mag());
    if (kind == 2) a.radius = 31'h7FFFFFFF;
    a.start_x = clamp32(cx + $signed($urandom_range(0, 2 * m)) - m);
    a.start_y = clamp32(cy + $signed($urandom_range(0, 2 * m)) - m);
    a.end_x = clamp32(cx + $signed($urandom_range(0, 2 * m)) - m);
    a.end_y = clamp32(cy + $signed($urandom_range(0, 2 * m)) - m);
    if (kind == 3) begin
      a.start_x = 32'(cx);
      a.start_y = 32'(cy);
    end
    if (kind == 4) begin
      a.end_x = 32'(cx);
      a.end_y = 32'(cy);
    end
    return a;
  endfunction

  function automatic abz_pkg::in_item_t make_arc(int cx, int cy, int r, int sx, int sy,
                                                 int ex, int ey);
    abz_pkg::in_item_t a;
    a.center_x = cx;
    a.center_y = cy;
    a.radius = 31'(r);
    a.start_x = sx;
    a.start_y = sy;
    a.end_x = ex;
    a.end_y = ey;
    return a;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (points_sb.pending_points.size() != 0) @(negedge clk);
  endtask

  initial begin
    int mx, mn;
    mx = 32'sh7FFFFFFF;
    mn = 32'sh80000000;
    in_valid = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed
    send_arc(make_arc(0, 0, 256, 256, 0, 0, 256));          // quarter turn
    send_arc(make_arc(0, 0, 256, 256, 0, 0, -256));         // negative quarter
    send_arc(make_arc(0, 0, 256, 256, 0, -256, 0));         // half turn
    send_arc(make_arc(0, 0, 256, -256, 0, 256, 0));         // half turn from the opposite start
    send_arc(make_arc(0, 0, 256, 256, 0, -256, 10));        // two segments
    send_arc(make_arc(0, 0, 256, 256, 0, -256, -10));       // two segments, negative
    send_arc(make_arc(0, 0, 512, 256, 0, 700, 0));          // zero sweep
    send_arc(make_arc(0, 0, 0, 256, 0, 0, 256));            // radius zero
    send_arc(make_arc(5, 5, 256, 5, 5, 0, 256));            // start at center
    send_arc(make_arc(5, 5, 256, 0, 256, 5, 5));            // end at center
    send_arc(make_arc(0, 0, 0, 0, 0, 0, 0));
    send_arc(make_arc(mx, mx, 32'h7FFFFFFF, mn, mx, mx, mn)); // saturation high
    send_arc(make_arc(mn, mn, 32'h7FFFFFFF, mx, mn, mn, mx)); // saturation low
    send_arc(make_arc(mx, mn, 32'h7FFFFFFF, mn, mn, mx, mx));
    send_arc(make_arc(0, 0, 1, 1, 0, 0, 1));
    send_arc(make_arc(mn, mn, 1000, mx, mx, mn + 1, mn));
    send_arc(make_arc(-1000, 300, 4096, -900, 300, -1000, 200));
    send_arc(make_arc(0, 0, 256, 1, 1000000, -1, 1000000)); // tiny sweep near up
    wait_drained();

    // random with a long receiver hold partway through
    for (int i = 0; i < 310; i++) begin
      if (i == 100) begin
        hold_rx = 1'b1;
        for (int j = 0; j < 40; j++) send_arc(rand_arc());
        hold_rx = 1'b0;
      end
      if (i == 200) wait_drained();
      send_arc(rand_arc());
    end

    wait_drained();
    repeat (LAT + 20) @(negedge clk);
    $display("covered %0d arcs: %0d degenerate, %0d split in two; %0d points checked",
             arcs_sent, degen_sent, two_seg_sent, points_sb.checked);
    if (fail_count == 0 && points_sb.pending_points.size() == 0) begin
      $display("arc_to_bezier_segmenter regression: pass");
    end else begin
      $display("arc_to_bezier_segmenter regression: fail");
    end
    $finish;
  end

  // ---------------- receiver ----------------
  initial begin
    int wait_cycles;
    int long_hold;
    out_stall = 1'b1;
    long_hold = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_rx && long_hold == 0) begin
        long_hold = 1;
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
      end
      wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
      if (wait_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) points_sb.check_point(out_data);
  end

endmodule

// ===== files.f =====
design/abz_pkg.sv
design/abz_norm_cell.sv
design/abz_vec_cell.sv
design/abz_rot_cell.sv
design/abz_div_cell.sv
design/arc_to_bezier_segmenter.sv
tb/tb_arc_to_bezier_segmenter.sv
